// ===== hw/rtl/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvrt_pkg
// shared constants, word types and command encoding of the route table
// ----------------------------------------------------------------------------
package dvrt_pkg;

	localparam int NODES   = 16;
	localparam int NODE_W  = $clog2(NODES);
	localparam int CNT_W   = $clog2(NODES + 1);
	localparam int COST_W  = 30;
	localparam int LIFE_W  = 16;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 3;
	localparam int MAT_D   = NODES * NODES;
	localparam int MAT_AW  = 2 * NODE_W;
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);

	localparam logic [COST_W-1:0] INF_COST = COST_W'(999999999);

	// input kinds
	localparam logic [1:0] KIND_INIT = 2'd0;
	localparam logic [1:0] KIND_RECV = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_ADV  = 2'd3;

	// result kinds
	localparam logic [1:0] RK_INIT = 2'd0;
	localparam logic [1:0] RK_UPD  = 2'd1;
	localparam logic [1:0] RK_TICK = 2'd2;
	localparam logic [1:0] RK_ADV  = 2'd3;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_SELF     = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_MASK     = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_LIFETIME = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_AGE      = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_POISON   = 3'd4;

	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        from_node;
		logic [3:0]        dest_node;
		logic [COST_W-1:0] adv_cost;
		logic              last_entry;
		logic [3:0]        target_node;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [3:0]        entry_dest;
		logic [COST_W-1:0] entry_cost;
		logic              final_item;
		logic              table_changed;
		logic              route_expired;
	} out_word_t;

	typedef enum logic [1:0] {OP_INIT, OP_RECV, OP_TICK, OP_ADV} op_t;

	typedef struct packed {
		op_t               op;
		logic [3:0]        from_node;
		logic [3:0]        dest_node;
		logic [COST_W-1:0] adv_cost;
		logic              last_entry;
		logic [3:0]        target_node;
		logic              from_self;
		logic              cost_inf;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  self_node;
		logic [15:0] neighbor_mask;
		logic [14:0] route_lifetime;
		logic [14:0] age_step;
		logic        poison_reverse;
	} cfg_t;

endpackage

// ===== hw/rtl/distance_vector_route_table.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_table
// distance-vector route table with poison reverse over sixteen nodes
// ----------------------------------------------------------------------------
// usage:
//   a command word is taken when start is high and busy is low; up to four
//   words wait in a queue while the sequencer works, busy rises when it is full
//   results appear on result for one cycle each, marked by result_valid; the
//   receiver cannot stall them
//   configuration is written through cfg_we, cfg_index and cfg_data while idle
// sequencer states per word, after the idle state that pops it from the queue:
//   init: ST_INIT, received entry: ST_RECV1 and ST_RECV2 (ST_RECV1 only from self),
//   last entry: also ST_RELAX (relaxation, one matrix ram read per cycle), tick: ST_TICK
//   over all NODES routes, advertise: ST_ADV with one entry word per cycle
//   every result is registered in the result register
// reset:
//   all routes infinite with no next hop, the advertised cost matrix reads as
//   infinity with a zero diagonal, registers take their default values
// ----------------------------------------------------------------------------
module distance_vector_route_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  dvrt_pkg::in_word_t            item,
	input  logic                          cfg_we,
	input  logic [dvrt_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [dvrt_pkg::CFG_W-1:0]    cfg_data,
	output logic                          result_valid,
	output dvrt_pkg::out_word_t           result
);
	import dvrt_pkg::*;

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.self_node      <= '0;
			cfg_q.neighbor_mask  <= '0;
			cfg_q.route_lifetime <= 15'd90;
			cfg_q.age_step       <= 15'd30;
			cfg_q.poison_reverse <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SELF:     cfg_q.self_node      <= cfg_data[3:0];
				CFG_MASK:     cfg_q.neighbor_mask  <= cfg_data[15:0];
				CFG_LIFETIME: cfg_q.route_lifetime <= cfg_data[14:0];
				CFG_AGE:      cfg_q.age_step       <= cfg_data[14:0];
				CFG_POISON:   cfg_q.poison_reverse <= cfg_data[0];
				default:      cfg_q                <= cfg_q;
			endcase
		end
	end

	dvrt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.self_node (cfg_q.self_node),
		.pop       (pop),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	dvrt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== hw/rtl/dvrt_ram.sv =====
// ----------------------------------------------------------------------------
// dvrt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module dvrt_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	parameter int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/dvrt_front.sv =====
// ----------------------------------------------------------------------------
// dvrt_front
// accepts command words, decodes them and queues them for the back end
// ----------------------------------------------------------------------------
module dvrt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  dvrt_pkg::in_word_t item,
	input  logic [3:0]       self_node,
	input  logic             pop,
	output logic             busy,
	output logic             cmd_valid,
	output dvrt_pkg::cmd_t   cmd
);
	import dvrt_pkg::*;

	cmd_t             q_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;
	cmd_t             dec;
	logic             push;
	logic             do_pop;

	// classify the incoming word
	always_comb begin
		dec.from_node   = item.from_node;
		dec.dest_node   = item.dest_node;
		dec.adv_cost    = item.adv_cost;
		dec.last_entry  = item.last_entry;
		dec.target_node = item.target_node;
		dec.from_self   = (item.from_node == self_node);
		dec.cost_inf    = (item.adv_cost == INF_COST);
		case (item.kind)
			KIND_INIT: dec.op = OP_INIT;
			KIND_RECV: dec.op = OP_RECV;
			KIND_TICK: dec.op = OP_TICK;
			default:   dec.op = OP_ADV;
		endcase
	end

	assign busy      = (cnt_q == (QAW+1)'(QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_ptr_q];
	assign push      = start && !busy;
	assign do_pop    = pop && cmd_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= dec;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/dvrt_back.sv =====
// ----------------------------------------------------------------------------
// dvrt_back
// executes queued commands on the route table and the advertised cost matrix
// ----------------------------------------------------------------------------
module dvrt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dvrt_pkg::cfg_t     cfg,
	input  logic               cmd_valid,
	input  dvrt_pkg::cmd_t     cmd,
	output logic               pop,
	output logic               result_valid,
	output dvrt_pkg::out_word_t result
);
	import dvrt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_INIT, ST_RECV1, ST_RECV2, ST_RELAX, ST_TICK, ST_ADV
	} state_t;

	state_t                    state_q;
	cmd_t                      cmd_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      changed_q;
	logic                      expired_q;
	logic                      pend_s1;
	logic [NODE_W-1:0]         x_s1;
	logic                      mvalid_s1;
	logic                      diag_s1;
	logic [MAT_D-1:0]          mvalid_q;

	logic [COST_W-1:0]         cost_q  [NODES];
	logic [NODE_W-1:0]         hop_q   [NODES];
	logic                      hopv_q  [NODES];
	logic signed [LIFE_W-1:0]  life_q  [NODES];

	logic                      ram_we;
	logic [MAT_AW-1:0]         ram_waddr;
	logic [COST_W-1:0]         ram_wdata;
	logic [MAT_AW-1:0]         ram_raddr;
	logic [COST_W-1:0]         ram_rdata;
	logic [COST_W-1:0]         mat_val;
	logic [NODE_W-1:0]         f_idx;
	logic [NODE_W-1:0]         d_idx;
	logic [NODE_W-1:0]         w_idx;
	logic [COST_W:0]           sum;
	logic                      relax_hit;
	logic signed [LIFE_W:0]    aged;
	logic signed [LIFE_W-1:0]  aged_sat;
	logic [COST_W-1:0]         adv_cost_out;
	logic signed [LIFE_W-1:0]  refresh_life;

	assign f_idx        = cmd_q.from_node[NODE_W-1:0];
	assign d_idx        = cmd_q.dest_node[NODE_W-1:0];
	assign w_idx        = cnt_q[NODE_W-1:0];
	assign refresh_life = {1'b0, cfg.route_lifetime};
	assign pop          = (state_q == ST_IDLE) && cmd_valid;

	// entry never written reads as its reset cost
	assign mat_val = mvalid_s1 ? ram_rdata : (diag_s1 ? '0 : INF_COST);

	// matrix port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {f_idx, d_idx};
		ram_wdata = '0;
		ram_raddr = {f_idx, w_idx};
		case (state_q)
			ST_RECV1: ram_raddr = {f_idx, d_idx};
			ST_RECV2: begin
				ram_we    = 1'b1;
				ram_wdata = cmd_q.cost_inf ? INF_COST :
					((cmd_q.adv_cost < mat_val) ? cmd_q.adv_cost : mat_val);
			end
			default: ram_raddr = {f_idx, w_idx};
		endcase
	end

	// relaxation through the sender, whose route was just refreshed to cost one
	assign sum       = (COST_W+1)'(1) + {1'b0, mat_val};
	assign relax_hit = pend_s1 && (x_s1 != cfg.self_node[NODE_W-1:0]) &&
		(sum < {1'b0, cost_q[x_s1]});

	// aging with saturation at the most negative lifetime
	always_comb begin
		aged = {life_q[w_idx][LIFE_W-1], life_q[w_idx]} - $signed({2'b00, cfg.age_step});
		if (aged < -(LIFE_W+1)'(32768)) begin
			aged_sat = {1'b1, {(LIFE_W-1){1'b0}}};
		end else begin
			aged_sat = aged[LIFE_W-1:0];
		end
	end

	// poison reverse toward the target
	assign adv_cost_out = (cfg.poison_reverse && hopv_q[w_idx] &&
		(hop_q[w_idx] == cmd_q.target_node[NODE_W-1:0]) && (cost_q[w_idx] != COST_W'(1)))
		? INF_COST : cost_q[w_idx];

	dvrt_ram #(.W(COST_W), .D(MAT_D), .AW(MAT_AW)) u_mat (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, route table and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			changed_q    <= 1'b0;
			expired_q    <= 1'b0;
			pend_s1      <= 1'b0;
			x_s1         <= '0;
			mvalid_s1    <= 1'b0;
			diag_s1      <= 1'b0;
			mvalid_q     <= '0;
			result_valid <= 1'b0;
			result       <= '0;
			cmd_q        <= '0;
			for (int i = 0; i < NODES; i++) begin
				cost_q[i] <= INF_COST;
				hop_q[i]  <= '0;
				hopv_q[i] <= 1'b0;
				life_q[i] <= '0;
			end
		end else begin
			result_valid <= 1'b0;
			result       <= '0;
			mvalid_s1    <= mvalid_q[ram_raddr];
			diag_s1      <= (ram_raddr[MAT_AW-1:NODE_W] == ram_raddr[NODE_W-1:0]);
			if (ram_we) begin
				mvalid_q[ram_waddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q     <= '0;
					changed_q <= 1'b0;
					expired_q <= 1'b0;
					pend_s1   <= 1'b0;
					if (cmd_valid) begin
						cmd_q <= cmd;
						case (cmd.op)
							OP_INIT: state_q <= ST_INIT;
							OP_RECV: state_q <= ST_RECV1;
							OP_TICK: state_q <= ST_TICK;
							default: state_q <= ST_ADV;
						endcase
					end
				end
				// build the table from the neighbor mask
				ST_INIT: begin
					mvalid_q <= '0;
					for (int i = 0; i < NODES; i++) begin
						life_q[i] <= refresh_life;
						if (NODE_W'(i) == cfg.self_node[NODE_W-1:0]) begin
							cost_q[i] <= '0;
							hop_q[i]  <= NODE_W'(i);
							hopv_q[i] <= 1'b1;
						end else if (cfg.neighbor_mask[i]) begin
							cost_q[i] <= COST_W'(1);
							hop_q[i]  <= NODE_W'(i);
							hopv_q[i] <= 1'b1;
						end else begin
							cost_q[i] <= INF_COST;
							hop_q[i]  <= '0;
							hopv_q[i] <= 1'b0;
						end
					end
					result_valid       <= 1'b1;
					result.result_kind <= RK_INIT;
					result.final_item  <= 1'b1;
					state_q            <= ST_IDLE;
				end
				// refresh the sender route
				ST_RECV1: begin
					if (cmd_q.from_self) begin
						if (cmd_q.last_entry) begin
							result_valid       <= 1'b1;
							result.result_kind <= RK_UPD;
							result.final_item  <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						cost_q[f_idx] <= COST_W'(1);
						hop_q[f_idx]  <= f_idx;
						hopv_q[f_idx] <= 1'b1;
						life_q[f_idx] <= refresh_life;
						state_q       <= ST_RECV2;
					end
				end
				// record the advertised cost (infinity, or the lower of it and the stored one) and touch the destination route
				ST_RECV2: begin
					if (cmd_q.cost_inf && (cost_q[d_idx] != COST_W'(1)) &&
						(d_idx != cfg.self_node[NODE_W-1:0])) begin
						cost_q[d_idx] <= INF_COST;
						hop_q[d_idx]  <= '0;
						hopv_q[d_idx] <= 1'b0;
						life_q[d_idx] <= '1;
					end
					if (hopv_q[d_idx] && (hop_q[d_idx] == f_idx) && !cmd_q.cost_inf) begin
						life_q[d_idx] <= refresh_life;
					end
					cnt_q   <= '0;
					pend_s1 <= 1'b0;
					state_q <= cmd_q.last_entry ? ST_RELAX : ST_IDLE;
				end
				// one matrix read issued and one route relaxed per cycle
				ST_RELAX: begin
					if (cnt_q < CNT_W'(NODES)) begin
						cnt_q   <= cnt_q + 1'b1;
						pend_s1 <= 1'b1;
						x_s1    <= w_idx;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (relax_hit) begin
						cost_q[x_s1] <= sum[COST_W-1:0];
						hop_q[x_s1]  <= f_idx;
						hopv_q[x_s1] <= 1'b1;
						life_q[x_s1] <= refresh_life;
						changed_q    <= 1'b1;
					end
					if (pend_s1 && (x_s1 == NODE_W'(NODES - 1))) begin
						result_valid         <= 1'b1;
						result.result_kind   <= RK_UPD;
						result.final_item    <= 1'b1;
						result.table_changed <= changed_q | relax_hit;
						state_q              <= ST_IDLE;
					end
				end
				// age one route per cycle
				ST_TICK: begin
					if (w_idx != cfg.self_node[NODE_W-1:0]) begin
						life_q[w_idx] <= aged_sat;
						if (aged_sat <= 0) begin
							cost_q[w_idx] <= INF_COST;
							hop_q[w_idx]  <= '0;
							hopv_q[w_idx] <= 1'b0;
							expired_q     <= 1'b1;
						end
					end
					cnt_q <= cnt_q + 1'b1;
					if (w_idx == NODE_W'(NODES - 1)) begin
						result_valid         <= 1'b1;
						result.result_kind   <= RK_TICK;
						result.final_item    <= 1'b1;
						result.route_expired <= expired_q |
							((w_idx != cfg.self_node[NODE_W-1:0]) && (aged_sat <= 0));
						state_q              <= ST_IDLE;
					end
				end
				// stream one entry per cycle
				ST_ADV: begin
					result_valid       <= 1'b1;
					result.result_kind <= RK_ADV;
					result.entry_dest  <= 4'(w_idx);
					result.entry_cost  <= adv_cost_out;
					result.final_item  <= (w_idx == NODE_W'(NODES - 1));
					cnt_q              <= cnt_q + 1'b1;
					if (w_idx == NODE_W'(NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// an advertisement run continues until its final word
	a_adv_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind == RK_ADV) && !result.final_item
		|=> result_valid && (result.result_kind == RK_ADV))
		else $error("advertisement run broken");

	// costs never exceed infinity
	a_cost_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.entry_cost <= INF_COST))
		else $error("cost above infinity");

	// single-word results are always final
	a_single_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind != RK_ADV) |-> result.final_item)
		else $error("non-final status word");

	// a pop always starts its command, moving the sequencer out of idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q != ST_IDLE))
		else $error("command popped but not started");

endmodule
